### sv/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg: shared types and constants of the radix glyph converter
// Glyph tables, register indexes, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgc_pkg;

  localparam int NUM_W          = 64;
  localparam int GLYPH_W        = 8;
  localparam int RADIX_W        = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEF_MAX_DIGITS = 64;

  localparam logic [RADIX_W-1:0]   RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0]   RADIX_MIN   = 6'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd1;
  localparam logic                 DIR_TO_GLYPH  = 1'b0;
  localparam logic                 DIR_TO_NUMBER = 1'b1;
  localparam logic [GLYPH_W-1:0]   GLYPH_PLUS    = 8'd43;
  localparam logic [RADIX_W-1:0]   DIGIT_UNKNOWN = 6'd62;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIGIT,
    S_EMIT_RD,
    S_EMIT_WR,
    S_ACC,
    S_NUM
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic div_step;
    logic digit_push;
    logic acc_step;
    logic out_digit;
    logic out_number;
  } cmd_t;

  typedef struct packed {
    logic direction;
    logic in_valid;
    logic last;
    logic bit_done;
    logic more;
    logic count_last;
    logic out_free;
  } sts_t;

  function automatic logic [GLYPH_W-1:0] digit_glyph(input logic [RADIX_W-1:0] d);
    logic [GLYPH_W-1:0] dw;
    dw = {2'b00, d};
    if (d inside {[6'd0:6'd9]}) begin
      return dw + 8'd48;
    end else if (d inside {[6'd10:6'd35]}) begin
      return dw + 8'd55;
    end else if (d inside {[6'd36:6'd61]}) begin
      return dw + 8'd61;
    end
    return GLYPH_PLUS;
  endfunction

  function automatic logic [RADIX_W-1:0] glyph_digit(input logic [GLYPH_W-1:0] g);
    logic [GLYPH_W-1:0] dw;
    dw = g;
    if (g inside {[8'd48:8'd57]}) begin
      dw = g - 8'd48;
      return dw[RADIX_W-1:0];
    end else if (g inside {[8'd65:8'd90]}) begin
      dw = g - 8'd55;
      return dw[RADIX_W-1:0];
    end else if (g inside {[8'd97:8'd122]}) begin
      dw = g - 8'd61;
      return dw[RADIX_W-1:0];
    end
    return DIGIT_UNKNOWN;
  endfunction

endpackage

### sv/radix_glyph_converter_core.sv
// ----------------------------------------------------------------------------
// radix_glyph_converter_core: number to digit glyph converter, base 2..63
// Direction 0 takes one 64-bit value and returns its digits most significant
// first, glyphs 0-9, A-Z, a-z and '+', run_last on the final one; zero gives
// a single '0'. Direction 1 takes glyphs and returns the value after the glyph
// marked last, with overflowed set if it passed VALUE_BITS bits. Digits come
// from a restoring divider that resolves one quotient bit a cycle; each digit
// is stored, then the digits are read back and sent as glyphs. A glyph in
// direction 1 is added in through a single multiply-add; after the last one
// the value is written to the output register.
// Only one value is worked on at a time; a result waiting in the output
// register does not stop the next glyph from being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module radix_glyph_converter_core import rgc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_W-1:0]     number_in,
  input  logic [GLYPH_W-1:0]   glyph_in,
  input  logic                 glyph_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [GLYPH_W-1:0]   glyph_out,
  output logic [NUM_W-1:0]     number_out,
  output logic                 overflowed,
  output logic                 run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIX_W-1:0]   cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign in_ready = cmd.in_ready;

  rgc_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  rgc_dpath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .number_in  (number_in),
    .glyph_in   (glyph_in),
    .glyph_last (glyph_last),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .glyph_out  (glyph_out),
    .number_out (number_out),
    .overflowed (overflowed),
    .run_last   (run_last),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### sv/rgc_dpath.sv
// ----------------------------------------------------------------------------
// rgc_dpath: datapath of the radix glyph converter
// Configuration registers, bit-serial divider, digit store, multiply-add
// accumulator and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgc_dpath import rgc_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [NUM_W-1:0]     number_in,
  input  logic [GLYPH_W-1:0]   glyph_in,
  input  logic                 glyph_last,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [GLYPH_W-1:0]   glyph_out,
  output logic [NUM_W-1:0]     number_out,
  output logic                 overflowed,
  output logic                 run_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RADIX_W-1:0]   cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int BIT_W = $clog2(VALUE_BITS);
  localparam int SUM_W = VALUE_BITS + RADIX_W + 1;

  logic [RADIX_W-1:0]    radix;
  logic                  direction;
  logic [VALUE_BITS-1:0] quo;
  logic [RADIX_W-1:0]    rem;
  logic [BIT_W-1:0]      bitcnt;
  logic [CNT_W-1:0]      count;
  logic                  trunc;
  logic [RADIX_W-1:0]    digit_store [MAX_DIGITS];
  logic [RADIX_W-1:0]    rd_data;
  logic [RADIX_W-1:0]    digit_q;
  logic                  last_q;
  logic [VALUE_BITS-1:0] acc;
  logic                  ovf_seen;

  logic                  in_fire;
  logic [RADIX_W:0]      trial;
  logic [RADIX_W:0]      diff;
  logic                  ge;
  logic [RADIX_W-1:0]    rem_next;
  logic [CNT_W-1:0]      count_dec;
  logic [IDX_W-1:0]      rd_addr;
  logic [SUM_W-2:0]      prod;
  logic [SUM_W-1:0]      sum;
  logic                  sum_ovf;

  assign in_fire   = in_valid && cmd.in_ready;
  assign cfg_ready = 1'b1;

  // one restoring division step
  assign trial    = {rem, quo[VALUE_BITS-1]};
  assign diff     = trial - {1'b0, radix};
  assign ge       = (trial >= {1'b0, radix});
  assign rem_next = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];

  assign count_dec = count - CNT_W'(1);
  assign rd_addr   = count_dec[IDX_W-1:0];

  // multiply-add with overflow detect
  assign prod    = {{RADIX_W{1'b0}}, acc} * {{VALUE_BITS{1'b0}}, radix};
  assign sum     = {1'b0, prod} + SUM_W'(digit_q);
  assign sum_ovf = |sum[SUM_W-1:VALUE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      radix     <= RADIX_RESET;
      direction <= DIR_TO_GLYPH;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RADIX: begin
          radix <= (cfg_data inside {6'd0, 6'd1}) ? RADIX_MIN : cfg_data;
        end
        REG_DIRECTION: begin
          direction <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      quo     <= number_in[VALUE_BITS-1:0];
      rem     <= '0;
      bitcnt  <= BIT_W'(VALUE_BITS - 1);
      digit_q <= glyph_digit(glyph_in);
      last_q  <= glyph_last;
    end else if (cmd.div_step) begin
      quo    <= {quo[VALUE_BITS-2:0], ge};
      rem    <= rem_next;
      bitcnt <= bitcnt - BIT_W'(1);
    end else if (cmd.digit_push) begin
      rem    <= '0;
      bitcnt <= BIT_W'(VALUE_BITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.digit_push) begin
      digit_store[count[IDX_W-1:0]] <= rem;
      trunc                         <= (quo != '0);
    end
    rd_data <= digit_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (in_fire) begin
      count <= '0;
    end else if (cmd.digit_push) begin
      count <= count + CNT_W'(1);
    end else if (cmd.out_digit) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.out_number) begin
      acc      <= '0;
      ovf_seen <= 1'b0;
    end else if (cmd.acc_step && !ovf_seen) begin
      if (sum_ovf) begin
        ovf_seen <= 1'b1;
      end else begin
        acc <= sum[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_digit || cmd.out_number) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_digit) begin
      glyph_out  <= digit_glyph(rd_data);
      number_out <= '0;
      overflowed <= trunc;
      run_last   <= (count == CNT_W'(1));
    end else if (cmd.out_number) begin
      glyph_out  <= '0;
      number_out <= NUM_W'(acc);
      overflowed <= ovf_seen;
      run_last   <= 1'b1;
    end
  end

  always_comb begin
    sts.direction  = direction;
    sts.in_valid   = in_valid;
    sts.last       = last_q;
    sts.bit_done   = (bitcnt == '0);
    sts.more       = (quo != '0) && (count < CNT_W'(MAX_DIGITS - 1));
    sts.count_last = (count == CNT_W'(1));
    sts.out_free   = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.out_digit || cmd.out_number))
    else $error("output word overwritten before taken");

  a_acc_held: assert property (@(posedge clk) disable iff (rst)
    (ovf_seen && !cmd.out_number) |=> (acc == $past(acc)))
    else $error("accumulator moved after overflow");

endmodule

### sv/rgc_ctrl.sv
// ----------------------------------------------------------------------------
// rgc_ctrl: controller of the radix glyph converter
// Sequences division, digit store, glyph emission and accumulation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgc_ctrl import rgc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sts.in_valid) begin
          state_next = (sts.direction == DIR_TO_NUMBER) ? S_ACC : S_DIV;
        end
      end
      S_DIV: begin
        if (sts.bit_done) begin
          state_next = S_DIGIT;
        end
      end
      S_DIGIT: begin
        state_next = sts.more ? S_DIV : S_EMIT_RD;
      end
      S_EMIT_RD: begin
        state_next = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (sts.out_free) begin
          state_next = sts.count_last ? S_IDLE : S_EMIT_RD;
        end
      end
      S_ACC: begin
        state_next = sts.last ? S_NUM : S_IDLE;
      end
      S_NUM: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:    cmd.in_ready   = 1'b1;
      S_DIV:     cmd.div_step   = 1'b1;
      S_DIGIT:   cmd.digit_push = 1'b1;
      S_EMIT_WR: cmd.out_digit  = sts.out_free;
      S_ACC:     cmd.acc_step   = 1'b1;
      S_NUM:     cmd.out_number = sts.out_free;
      default: begin
      end
    endcase
  end

  a_acc_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.acc_step |-> $past(cmd.in_ready && sts.in_valid))
    else $error("accumulate without a taken glyph");

  a_idle_after_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_digit && sts.count_last) |=> cmd.in_ready)
    else $error("controller not idle after final digit");

endmodule
